// ===== rtl/brf_pkg.sv =====
package brf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLR   = 2'd2,
    CMD_FLUSH = 2'd3
  } brf_cmd_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] data_in;
  } brf_in_t;

  typedef struct packed {
    logic              accepted;
    logic [BYTE_W-1:0] data_out;
    logic [FILL_W-1:0] fill_level;
    logic [FILL_W-1:0] peak_fill;
    logic [CNT_W-1:0]  puts_done;
    logic [CNT_W-1:0]  gets_done;
    logic [CNT_W-1:0]  drops_done;
  } brf_out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } brf_cell_ctl_t;

  typedef struct packed {
    logic put_ok;
    logic get_ok;
    logic drop;
    logic clr;
  } brf_evt_t;

endpackage

// ===== rtl/byte_ring_fifo_with_stats_core.sv =====
// the result of an item is registered and valid in the cycle after the item is accepted
// throughput: one item per cycle while out_ready_i stays high; a new item is taken while the result is taken
// the queue is a row of byte cells: put loads the cell at the fill position,
// get shifts every cell one place toward the head
// reset (async, active low) empties the queue and zeroes peak and counters
module byte_ring_fifo_with_stats_core #(
  parameter int unsigned DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brf_pkg::brf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brf_pkg::brf_out_t out_data_o
);
  import brf_pkg::*;

  localparam int unsigned LVL_W = $clog2(DEPTH) + 1;

  logic              fire;
  logic              full;
  logic              empty;
  brf_evt_t          evt;
  logic              flush;
  logic [LVL_W-1:0]  fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  logic              acc_q;
  logic [BYTE_W-1:0] dout_q;
  logic [BYTE_W-1:0] cell_q [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (fill_q == LVL_W'(DEPTH));
  assign empty      = (fill_q == '0);

  always_comb begin
    evt   = '0;
    flush = 1'b0;
    case (in_data_i.command)
      CMD_PUT: begin
        evt.put_ok = !full;
        evt.drop   = full;
      end
      CMD_GET: begin
        evt.get_ok = !empty;
      end
      CMD_CLR: begin
        evt.clr = 1'b1;
      end
      CMD_FLUSH: begin
        evt.clr = 1'b1;
        flush   = 1'b1;
      end
      default: begin
        evt = '0;
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (fire) begin
      if (flush) begin
        fill_d = '0;
      end else if (evt.put_ok) begin
        fill_d = fill_q + LVL_W'(1);
      end else if (evt.get_ok) begin
        fill_d = fill_q - LVL_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q  <= evt.put_ok || evt.get_ok || evt.clr;
      dout_q <= evt.get_ok ? cell_q[0] : '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    brf_cell_ctl_t     ctl;
    logic [BYTE_W-1:0] nbr;

    assign ctl.shift = fire && evt.get_ok;
    assign ctl.load  = fire && evt.put_ok && (fill_q == LVL_W'(i));

    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    brf_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .din_i (in_data_i.data_in),
      .nbr_i (nbr),
      .q_o   (cell_q[i])
    );
  end

  brf_stats #(
    .LVL_W (LVL_W)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .evt_i    (evt),
    .fill_d_i (fill_d),
    .peak_o   (out_data_o.peak_fill),
    .puts_o   (out_data_o.puts_done),
    .gets_o   (out_data_o.gets_done),
    .drops_o  (out_data_o.drops_done)
  );

  assign out_valid_o           = out_valid_q;
  assign out_data_o.accepted   = acc_q;
  assign out_data_o.data_out   = dout_q;
  assign out_data_o.fill_level = FILL_W'(fill_q);

endmodule

// ===== rtl/brf_cell.sv =====
module brf_cell (
  input  logic                  clk_i,
  input  brf_pkg::brf_cell_ctl_t ctl_i,
  input  logic [7:0]            din_i,
  input  logic [7:0]            nbr_i,
  output logic [7:0]            q_o
);
  import brf_pkg::*;

  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = din_i;
    end else if (ctl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

// ===== rtl/brf_stats.sv =====
module brf_stats #(
  parameter int unsigned LVL_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  brf_pkg::brf_evt_t evt_i,
  input  logic [LVL_W-1:0]  fill_d_i,
  output logic [8:0]        peak_o,
  output logic [31:0]       puts_o,
  output logic [31:0]       gets_o,
  output logic [31:0]       drops_o
);
  import brf_pkg::*;

  logic [LVL_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0] puts_q, puts_d;
  logic [CNT_W-1:0] gets_q, gets_d;
  logic [CNT_W-1:0] drops_q, drops_d;

  always_comb begin
    peak_d  = peak_q;
    puts_d  = puts_q;
    gets_d  = gets_q;
    drops_d = drops_q;
    if (fire_i) begin
      if (evt_i.clr) begin
        peak_d  = '0;
        puts_d  = '0;
        gets_d  = '0;
        drops_d = '0;
      end else begin
        if (evt_i.put_ok) begin
          puts_d = puts_q + CNT_W'(1);
          if (fill_d_i > peak_q) begin
            peak_d = fill_d_i;
          end
        end
        if (evt_i.get_ok) begin
          gets_d = gets_q + CNT_W'(1);
        end
        if (evt_i.drop) begin
          drops_d = drops_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      puts_q  <= '0;
      gets_q  <= '0;
      drops_q <= '0;
    end else begin
      peak_q  <= peak_d;
      puts_q  <= puts_d;
      gets_q  <= gets_d;
      drops_q <= drops_d;
    end
  end

  assign peak_o  = FILL_W'(peak_q);
  assign puts_o  = puts_q;
  assign gets_o  = gets_q;
  assign drops_o = drops_q;

endmodule

// ===== bench/tb_byte_ring_fifo_with_stats_core.sv =====
`timescale 1ns / 100ps

module tb_byte_ring_fifo_with_stats_core;
  import brf_pkg::*;

  localparam int DEPTH = 256;
  localparam int STALL_LIMIT = 2000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  brf_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  brf_out_t out_data_o;

  byte_ring_fifo_with_stats_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  ring_mem [DEPTH];
  logic [8:0]  wr_idx = '0;
  logic [8:0]  rd_idx = '0;
  logic [8:0]  peak_lvl = '0;
  logic [31:0] put_cnt = '0;
  logic [31:0] get_cnt = '0;
  logic [31:0] drop_cnt = '0;

  brf_out_t fifo_expect_q[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  function automatic brf_out_t predict_fifo(brf_in_t item);
    brf_out_t   res;
    logic [8:0] lvl;
    res = '0;
    lvl = wr_idx - rd_idx;
    case (brf_cmd_e'(item.command))
      CMD_PUT: begin
        if (lvl >= 9'(DEPTH)) begin
          drop_cnt = drop_cnt + 1;
        end else begin
          ring_mem[wr_idx[7:0]] = item.data_in;
          wr_idx = wr_idx + 9'd1;
          put_cnt = put_cnt + 1;
          lvl = wr_idx - rd_idx;
          if (lvl > peak_lvl) begin
            peak_lvl = lvl;
          end
          res.accepted = 1'b1;
        end
      end
      CMD_GET: begin
        if (lvl != 0) begin
          res.data_out = ring_mem[rd_idx[7:0]];
          rd_idx = rd_idx + 9'd1;
          get_cnt = get_cnt + 1;
          res.accepted = 1'b1;
        end
      end
      CMD_CLR: begin
        peak_lvl = '0;
        put_cnt = '0;
        get_cnt = '0;
        drop_cnt = '0;
        res.accepted = 1'b1;
      end
      default: begin
        wr_idx = '0;
        rd_idx = '0;
        peak_lvl = '0;
        put_cnt = '0;
        get_cnt = '0;
        drop_cnt = '0;
        res.accepted = 1'b1;
      end
    endcase
    res.fill_level = wr_idx - rd_idx;
    res.peak_fill = peak_lvl;
    res.puts_done = put_cnt;
    res.gets_done = get_cnt;
    res.drops_done = drop_cnt;
    return res;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    brf_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (fifo_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %p", out_data_o);
          end
        end else begin
          want = fifo_expect_q.pop_front();
          cmp_field("accepted", 32'(want.accepted), 32'(out_data_o.accepted));
          cmp_field("data_out", 32'(want.data_out), 32'(out_data_o.data_out));
          cmp_field("fill_level", 32'(want.fill_level), 32'(out_data_o.fill_level));
          cmp_field("peak_fill", 32'(want.peak_fill), 32'(out_data_o.peak_fill));
          cmp_field("puts_done", want.puts_done, out_data_o.puts_done);
          cmp_field("gets_done", want.gets_done, out_data_o.gets_done);
          cmp_field("drops_done", want.drops_done, out_data_o.drops_done);
        end
      end
      if (in_valid_i && in_ready_o) begin
        fifo_expect_q.push_back(predict_fifo(in_data_i));
      end
    end
  end

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_byte_ring_fifo_with_stats_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(brf_cmd_e op, logic [7:0] byte_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{command: op, data_in: byte_val};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic put_burst(int n);
    repeat (n) send_cmd(CMD_PUT, 8'($urandom_range(255)));
  endtask

  task automatic get_burst(int n);
    repeat (n) send_cmd(CMD_GET, 8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_cmd(CMD_GET, 8'hff);
    send_cmd(CMD_PUT, 8'h00);
    send_cmd(CMD_PUT, 8'hff);
    send_cmd(CMD_PUT, 8'ha5);
    send_cmd(CMD_PUT, 8'h5a);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_GET, 8'h00);
    // clear with bytes still held
    send_cmd(CMD_CLR, 8'h00);
    send_cmd(CMD_PUT, 8'h81);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_PUT, 8'h7e);
    send_cmd(CMD_PUT, 8'h3c);
    // flush with bytes still held
    send_cmd(CMD_FLUSH, 8'hff);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_PUT, 8'hc3);
    send_cmd(CMD_GET, 8'h00);
    send_cmd(CMD_CLR, 8'hff);
  endtask

  task automatic test_fill_and_drain();
    send_cmd(CMD_FLUSH, 8'h00);
    put_burst(DEPTH + 4);
    get_burst(DEPTH + 2);
  endtask

  task automatic test_random_traffic(int n_items);
    int left;
    int pick;
    int len;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = $urandom_range(1, 40);
      end else if (pick < 45) begin
        len = $urandom_range(200, 300);
      end else if (pick < 70) begin
        len = $urandom_range(1, 48);
      end else if (pick < 80) begin
        len = $urandom_range(200, 300);
      end else begin
        len = 1;
      end
      if (len > left) begin
        len = left;
      end
      if (pick < 45) begin
        put_burst(len);
      end else if (pick < 80) begin
        get_burst(len);
      end else if (pick < 86) begin
        send_cmd(CMD_CLR, 8'($urandom_range(255)));
      end else if (pick < 90) begin
        send_cmd(CMD_FLUSH, 8'($urandom_range(255)));
      end else begin
        send_cmd(brf_cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
      end
      left -= len;
    end
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    put_burst(30);
    get_burst(10);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    recv_idle_pct = 56;
    test_directed();
    test_fill_and_drain();

    send_idle_pct = 56;
    recv_idle_pct = 7;
    test_random_traffic(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);
    test_backpressure();

    in_valid_i <= 1'b0;
    while (fifo_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatches == 0 && fifo_expect_q.size() == 0) begin
      $display("tb_byte_ring_fifo_with_stats_core OK");
    end else begin
      $display("tb_byte_ring_fifo_with_stats_core NOT OK");
    end
    $finish;
  end

endmodule
